FILE: hdl/bsb_pkg.sv
// shared types for the bubble sort buffer
// holds the command item passed from front to back and the back-end state codes
// no dependencies
package bsb_pkg;

  localparam int unsigned DATA_W = 32;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     store;    // value goes into the store
    logic                     last;     // closes the batch
    logic                     dropped;  // batch lost at least one item
  } cmd_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD0,
    S_RD1,
    S_STEP,
    S_LAST,
    S_EMIT_RD,
    S_EMIT_OUT
  } back_state_e;

endpackage

FILE: hdl/bsb_front.sv
// front end of the bubble sort buffer: counts the batch and classifies items
// depends on bsb_pkg
module bsb_front #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic signed [bsb_pkg::DATA_W-1:0] item_value_i,
  input  logic                              batch_end_i,
  output bsb_pkg::cmd_t                     cmd_o
);
  import bsb_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             dropped_q, dropped_d;
  logic             store;

  assign store = (count_q < CNT_W'(MAX_ITEMS));

  always_comb begin
    cmd_o.value   = item_value_i;
    cmd_o.store   = store;
    cmd_o.last    = batch_end_i;
    cmd_o.dropped = dropped_q | ~store;
    count_d       = count_q;
    dropped_d     = dropped_q;
    if (accept_i) begin
      if (batch_end_i) begin
        count_d   = '0;
        dropped_d = 1'b0;
      end else if (store) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

endmodule

FILE: hdl/bsb_fifo.sv
// two-entry queue of command items between front and back
// depends on bsb_pkg
module bsb_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsb_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output bsb_pkg::cmd_t data_o,
  output logic          empty_o
);
  import bsb_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

FILE: hdl/bsb_back.sv
// back end of the bubble sort buffer: store, sort passes and result register
// depends on bsb_pkg
module bsb_back #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bsb_pkg::cmd_t                     cmd_i,
  input  logic                              cmd_empty_i,
  output logic                              cmd_pop_o,
  output logic signed [bsb_pkg::DATA_W-1:0] sorted_value_o,
  output logic                              final_flag_o,
  output logic                              overflow_flag_o,
  output logic                              empty_o,
  input  logic                              pop_i
);
  import bsb_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);

  logic signed [DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [DATA_W-1:0] rd_data_q;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     we;
  logic [ADDR_W-1:0]        wa;
  logic signed [DATA_W-1:0] wd;

  back_state_e              state_q, state_d;
  logic [CNT_W-1:0]         n_q, n_d;
  logic [CNT_W-1:0]         limit_q, limit_d;
  logic [ADDR_W-1:0]        ridx_q, ridx_d;
  logic [ADDR_W-1:0]        k_q, k_d;
  logic signed [DATA_W-1:0] carry_q, carry_d;
  logic                     drop_q, drop_d;

  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_final_q, out_over_q, out_valid_q;
  logic                     out_load, out_final_d;

  logic [CNT_W-1:0]         n_new;
  logic [CNT_W-1:0]         lim_m1;

  assign sorted_value_o  = out_value_q;
  assign final_flag_o    = out_final_q;
  assign overflow_flag_o = out_over_q;
  assign empty_o         = ~out_valid_q;

  assign n_new  = cmd_i.store ? n_q + CNT_W'(1) : n_q;
  assign lim_m1 = limit_q - CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    limit_d     = limit_q;
    ridx_d      = ridx_q;
    k_d         = k_q;
    carry_d     = carry_q;
    drop_d      = drop_q;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    wa          = '0;
    wd          = cmd_i.value;
    rd_addr     = '0;
    out_load    = 1'b0;
    out_final_d = (CNT_W'(k_q) == n_q - CNT_W'(1));
    unique case (state_q)
      S_LOAD: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.store) begin
            we = 1'b1;
            wa = n_q[ADDR_W-1:0];
          end
          n_d = n_new;
          if (cmd_i.last) begin
            drop_d  = cmd_i.dropped;
            limit_d = n_new;
            k_d     = '0;
            state_d = (n_new > CNT_W'(1)) ? S_RD0 : S_EMIT_RD;
          end
        end
      end
      S_RD0: begin
        rd_addr = '0;
        state_d = S_RD1;
      end
      S_RD1: begin
        carry_d = rd_data_q;
        rd_addr = ADDR_W'(1);
        ridx_d  = ADDR_W'(1);
        state_d = S_STEP;
      end
      S_STEP: begin
        // smaller of the pair drops back one place, larger rides along
        we = 1'b1;
        wa = ridx_q - ADDR_W'(1);
        if (carry_q > rd_data_q) begin
          wd = rd_data_q;
        end else begin
          wd      = carry_q;
          carry_d = rd_data_q;
        end
        if (CNT_W'(ridx_q) == lim_m1) begin
          state_d = S_LAST;
        end else begin
          rd_addr = ridx_q + ADDR_W'(1);
          ridx_d  = ridx_q + ADDR_W'(1);
        end
      end
      S_LAST: begin
        we      = 1'b1;
        wa      = lim_m1[ADDR_W-1:0];
        wd      = carry_q;
        limit_d = lim_m1;
        state_d = (lim_m1 > CNT_W'(1)) ? S_RD0 : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        rd_addr = k_q;
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        rd_addr = k_q;
        if (!out_valid_q || pop_i) begin
          out_load = 1'b1;
          if (out_final_d) begin
            n_d     = '0;
            drop_d  = 1'b0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + ADDR_W'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    limit_q <= limit_d;
    ridx_q  <= ridx_d;
    k_q     <= k_d;
    carry_q <= carry_d;
    if (out_load) begin
      out_value_q <= rd_data_q;
      out_final_q <= out_final_d;
      out_over_q  <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      n_q         <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      drop_q  <= drop_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/bubble_sort_buffer.sv
// top level of the bubble sort buffer: batch sorter for signed 32-bit values
// depends on bsb_pkg, bsb_front, bsb_fifo and bsb_back
//
//   channel   handshake          payload
//   input     push_i / full_o    item_value_i, batch_end_i
//   result    pop_i / empty_o    sorted_value_o, final_flag_o, overflow_flag_o
//
// a batch of n items: the items are loaded one after another, then n-1
// passes with limit running from n down to 2, then each result is read from
// the store and loaded into the result register; the pace is set by the single
// read port and single write port of the store. no clearing pass after reset.
// the front keeps accepting items of the next batch while the back sorts,
// until the two-entry command queue fills; full_o stalls the input then.
// a stalled result holds on the result ports until popped.
module bubble_sort_buffer #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic signed [bsb_pkg::DATA_W-1:0] item_value_i,
  input  logic                              batch_end_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic signed [bsb_pkg::DATA_W-1:0] sorted_value_o,
  output logic                              final_flag_o,
  output logic                              overflow_flag_o
);
  import bsb_pkg::*;

  cmd_t front_cmd;   // classified item from the front
  cmd_t back_cmd;    // head of the command queue
  logic accept;      // input item taken this cycle
  logic cmd_empty;
  logic cmd_pop;

  assign accept = push_i & ~full_o;

  // batch counting, overflow detection
  bsb_front #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_value_i(item_value_i),
    .batch_end_i (batch_end_i),
    .cmd_o       (front_cmd)
  );

  // decouples front from back
  bsb_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (front_cmd),
    .full_o (full_o),
    .pop_i  (cmd_pop),
    .data_o (back_cmd),
    .empty_o(cmd_empty)
  );

  // store, bubble passes and result register
  bsb_back #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (back_cmd),
    .cmd_empty_i    (cmd_empty),
    .cmd_pop_o      (cmd_pop),
    .sorted_value_o (sorted_value_o),
    .final_flag_o   (final_flag_o),
    .overflow_flag_o(overflow_flag_o),
    .empty_o        (empty_o),
    .pop_i          (pop_i)
  );

endmodule

FILE: dv/tb_bubble_sort_buffer.sv
`timescale 1ns / 1ps
// self-checking testbench for bubble_sort_buffer: sends batches of signed values,
// predicts each closed batch in sorted order and checks every result in turn
// depends on bsb_pkg and the bubble_sort_buffer rtl
module tb_bubble_sort_buffer;
  import bsb_pkg::*;

  localparam int unsigned STORE_DEPTH   = 64;
  localparam int unsigned MAX_PRINTED   = 20;
  localparam int unsigned SETTLE_CYCLES = 200;
  // bound on the drain wait, well beyond what a full batch takes to sort
  localparam int unsigned DRAIN_LIMIT   = STORE_DEPTH * STORE_DEPTH * 8;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t VAL_MAX = 32'sh7fff_ffff;
  localparam word_t VAL_MIN = 32'sh8000_0000;

  // one sorted value as it should leave the block
  typedef struct {
    word_t value;
    logic  last;
    logic  overflow;
  } sorted_item_t;

  // dut ports, all inputs known from time zero
  logic  clk_i        = 1'b0;
  logic  rst_ni       = 1'b0;
  logic  push_i       = 1'b0;
  word_t item_value_i = '0;
  logic  batch_end_i  = 1'b0;
  logic  pop_i        = 1'b0;
  logic  full_o;
  logic  empty_o;
  word_t sorted_value_o;
  logic  final_flag_o;
  logic  overflow_flag_o;

  // batch being loaded, mirrored here
  word_t       batch_store [STORE_DEPTH];
  int unsigned batch_fill = 0;
  logic        batch_lost = 1'b0;

  // sorted values still owed by the block, oldest first
  sorted_item_t sorted_q [$];

  // idle percentages per side and the long receiver hold-off
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned rx_hold_left  = 0;
  int unsigned err_count     = 0;

  bubble_sort_buffer #(
    .MAX_ITEMS(STORE_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .item_value_i   (item_value_i),
    .batch_end_i    (batch_end_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .sorted_value_o (sorted_value_o),
    .final_flag_o   (final_flag_o),
    .overflow_flag_o(overflow_flag_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // append one accepted item; on batch end sort what is held and queue the burst
  task automatic add_to_batch(input word_t v, input logic e);
    word_t       tmp;
    int unsigned limit;
    if (batch_fill < STORE_DEPTH) begin
      batch_store[batch_fill] = v;
      batch_fill++;
    end else begin
      // store full: the item is lost, batch end or not
      batch_lost = 1'b1;
    end
    if (e) begin
      // passes shrink by one; equal values stay put, so the order is stable
      for (limit = batch_fill; limit > 1; limit--) begin
        for (int unsigned i = 0; i + 1 < limit; i++) begin
          if (batch_store[i] > batch_store[i+1]) begin
            tmp              = batch_store[i];
            batch_store[i]   = batch_store[i+1];
            batch_store[i+1] = tmp;
          end
        end
      end
      for (int unsigned k = 0; k < batch_fill; k++) begin
        sorted_q.push_back('{batch_store[k], (k + 1 == batch_fill), batch_lost});
      end
      batch_fill = 0;
      batch_lost = 1'b0;
    end
  endtask

  // offer one item until taken; random gaps before it, with noise on the payload
  task automatic push_item(input word_t v, input logic e);
    while ($urandom_range(99) < src_idle_pct) begin
      push_i       <= 1'b0;
      item_value_i <= word_t'($urandom);
      batch_end_i  <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    push_i       <= 1'b1;
    item_value_i <= v;
    batch_end_i  <= e;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    add_to_batch(v, e);
  endtask

  // mix of extremes, a narrow band around zero for ties, and full-range values
  function automatic word_t rand_value();
    case ($urandom_range(9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return word_t'(int'($urandom_range(8)) - 4);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic push_batch(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_item(rand_value(), (i + 1 == len));
  endtask

  // sender goes quiet, then a bounded wait until every owed result has been popped
  task automatic wait_drained();
    int unsigned cycles;
    push_i <= 1'b0;
    cycles = 0;
    while (sorted_q.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
  endtask

  // single-item batches at the extremes, a pair out of order, ties, a sorted run
  task automatic test_edge_batches();
    push_item(VAL_MAX, 1'b1);
    push_item(VAL_MIN, 1'b1);
    push_item('0, 1'b1);
    push_item(VAL_MAX, 1'b0);
    push_item(VAL_MIN, 1'b1);
    push_item(5, 1'b0);
    push_item(-1, 1'b0);
    push_item('0, 1'b0);
    push_item(-1, 1'b0);
    push_item(VAL_MIN, 1'b0);
    push_item(VAL_MAX, 1'b0);
    push_item(5, 1'b1);
    push_item(-3, 1'b0);
    push_item(-2, 1'b0);
    push_item(-1, 1'b0);
    push_item('0, 1'b0);
    push_item(1, 1'b1);
    wait_drained();
  endtask

  // store filled to the brim, then the closing item itself is dropped
  task automatic test_store_limit();
    push_batch(STORE_DEPTH + 1);
    wait_drained();
  endtask

  // receiver holds off while small batches keep coming, so full_o must stall input
  task automatic test_receiver_stall();
    rx_hold_left <= 400;
    repeat (12) push_batch(3);
    wait_drained();
  endtask

  // mostly short batches, some medium, a rare one around the store depth
  task automatic test_random_batches(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80)      len = $urandom_range(8, 1);
      else if (pick < 95) len = $urandom_range(24, 9);
      else                len = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH - 4);
      push_batch(len);
      sent += len;
    end
  endtask

  // receiver: random pop, forced low while a hold-off counts down
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      pop_i        <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      pop_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // compare every popped result with the oldest owed one
  always @(posedge clk_i) begin : result_check
    sorted_item_t exp_item;
    if (rst_ni && pop_i && !empty_o) begin
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", sorted_value_o));
      end else begin
        exp_item = sorted_q.pop_front();
        if (sorted_value_o !== exp_item.value)
          report_mismatch($sformatf("sorted_value %0d, want %0d",
                                    sorted_value_o, exp_item.value));
        if (final_flag_o !== exp_item.last)
          report_mismatch($sformatf("final_flag %b, want %b",
                                    final_flag_o, exp_item.last));
        if (overflow_flag_o !== exp_item.overflow)
          report_mismatch($sformatf("overflow_flag %b, want %b",
                                    overflow_flag_o, exp_item.overflow));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // slow receiver
    src_idle_pct  = 34;
    sink_idle_pct = 83;
    test_edge_batches();
    test_store_limit();
    test_random_batches(10);
    wait_drained();

    // slow sender
    src_idle_pct  = 83;
    sink_idle_pct = 34;
    test_random_batches(10);
    wait_drained();

    // full rate both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_receiver_stall();
    test_random_batches(10);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sorted_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sorted_q.size()));
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
